// File: design/thcv_pkg.sv
// shared types, constants and helpers for the tcp header checksum verifier
package thcv_pkg;

  localparam logic [15:0] ProtoTcp    = 16'd6;
  localparam logic [5:0]  MinHdrBytes = 6'd20;
  localparam logic [7:0]  FlagFin     = 8'h01;
  localparam logic [7:0]  FlagSyn     = 8'h02;
  localparam logic [7:0]  FlagRst     = 8'h04;
  localparam logic [7:0]  FlagAck     = 8'h10;
  localparam int unsigned HdrBytes    = 16;
  localparam logic [15:0] CsumHiPos   = 16'd16;
  localparam logic [15:0] CsumLoPos   = 16'd17;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);

  // one classified byte on its way from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        first;
    logic        odd;
    logic        cap;
    logic [3:0]  cap_idx;
    logic        csum_hi;
    logic        csum_lo;
    logic [15:0] pseudo;
  } item_t;

  // end-around carry of a 17 bit sum
  function automatic logic [15:0] fold17(input logic [16:0] s);
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// File: design/thcv_front.sv
// front end: byte position tracking, pseudo-header sum and byte classification
module thcv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic [7:0]          data_byte_i,
  input  logic                is_last_i,
  input  logic [31:0]         src_ip_i,
  input  logic [31:0]         dst_ip_i,
  input  logic [15:0]         ip_total_len_i,
  input  logic [5:0]          ip_hdr_len_i,
  output thcv_pkg::item_t     item_o
);
  import thcv_pkg::*;

  logic        in_pkt_q, in_pkt_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] pos;
  logic [15:0] seg_len;
  logic [18:0] wide_sum;
  logic [16:0] part_sum;

  assign pos     = in_pkt_q ? cnt_q : 16'd0;
  assign seg_len = ip_total_len_i - {10'd0, ip_hdr_len_i};

  // six pseudo-header words, folded twice
  assign wide_sum = {3'd0, src_ip_i[31:16]} + {3'd0, src_ip_i[15:0]}
                  + {3'd0, dst_ip_i[31:16]} + {3'd0, dst_ip_i[15:0]}
                  + {3'd0, ProtoTcp} + {3'd0, seg_len};
  assign part_sum = {1'b0, wide_sum[15:0]} + {14'd0, wide_sum[18:16]};

  always_comb begin
    item_o.data    = data_byte_i;
    item_o.last    = is_last_i;
    item_o.first   = !in_pkt_q;
    item_o.odd     = pos[0];
    item_o.cap     = (pos < 16'(HdrBytes));
    item_o.cap_idx = pos[3:0];
    item_o.csum_hi = (pos == CsumHiPos);
    item_o.csum_lo = (pos == CsumLoPos);
    item_o.pseudo  = fold17(part_sum);
  end

  always_comb begin
    in_pkt_d = in_pkt_q;
    cnt_d    = cnt_q;
    if (acc_i) begin
      if (is_last_i) begin
        in_pkt_d = 1'b0;
        cnt_d    = 16'd0;
      end else begin
        in_pkt_d = 1'b1;
        cnt_d    = pos + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q <= 1'b0;
      cnt_q    <= 16'd0;
    end else begin
      in_pkt_q <= in_pkt_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: design/thcv_queue.sv
// short queue of classified bytes between front and back
module thcv_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  thcv_pkg::item_t   item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output thcv_pkg::item_t   item_o
);
  import thcv_pkg::*;

  item_t                  mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QueuePtrW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{QueuePtrW{1'b0}}, push_i} - {{QueuePtrW{1'b0}}, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: design/thcv_back.sv
// back end: checksum accumulation, header capture and result register
module thcv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  thcv_pkg::item_t   item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       source_port_o,
  output logic [15:0]       dest_port_o,
  output logic [31:0]       seq_number_o,
  output logic [31:0]       ack_number_o,
  output logic [5:0]        header_bytes_o,
  output logic              syn_flag_o,
  output logic              rst_flag_o,
  output logic              fin_flag_o,
  output logic              ack_flag_o,
  output logic [15:0]       window_size_o,
  output logic              checksum_ok_o,
  output logic [15:0]       computed_checksum_o
);
  import thcv_pkg::*;

  logic [15:0] sum_q, sum_d;
  logic [7:0]  pend_q, pend_d;
  logic [7:0]  hdr_q [HdrBytes];
  logic [7:0]  hdr_d [HdrBytes];
  logic [15:0] rcv_q, rcv_d;
  logic        out_valid_q, out_valid_d;

  logic [15:0] base;
  logic [7:0]  eff;
  logic [15:0] word;
  logic        add;
  logic [15:0] sum_n;
  logic [15:0] csum;
  logic [5:0]  hb;

  // a last beat waits while an undelivered result sits in the output register
  assign pop_o = valid_i && (!item_i.last || !out_valid_q || !out_stall_i);

  always_comb begin
    base  = item_i.first ? item_i.pseudo : sum_q;
    eff   = (item_i.csum_hi || item_i.csum_lo) ? 8'd0 : item_i.data;
    if (item_i.odd) begin
      word = {pend_q, eff};
      add  = 1'b1;
    end else begin
      word = {eff, 8'd0};
      add  = item_i.last;
    end
    sum_n = add ? fold17({1'b0, base} + {1'b0, word}) : base;
    csum  = ~sum_n;
  end

  always_comb begin
    sum_d  = sum_q;
    pend_d = pend_q;
    rcv_d  = rcv_q;
    for (int i = 0; i < HdrBytes; i++) begin
      hdr_d[i] = hdr_q[i];
    end
    if (pop_o) begin
      sum_d = sum_n;
      if (!item_i.odd) begin
        pend_d = eff;
      end
      rcv_d = item_i.first ? 16'd0 : rcv_q;
      if (item_i.csum_hi) begin
        rcv_d[15:8] = item_i.data;
      end
      if (item_i.csum_lo) begin
        rcv_d[7:0] = item_i.data;
      end
      // header bytes accumulate by or, even after a position wrap
      for (int i = 0; i < HdrBytes; i++) begin
        hdr_d[i] = (item_i.first ? 8'd0 : hdr_q[i])
                 | ((item_i.cap && (item_i.cap_idx == 4'(i))) ? item_i.data : 8'd0);
      end
    end
  end

  always_comb begin
    hb = (hdr_d[12][7:4] < 4'd5) ? MinHdrBytes : {hdr_d[12][7:4], 2'b00};
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o && item_i.last) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= 16'd0;
      pend_q      <= 8'd0;
      rcv_q       <= 16'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < HdrBytes; i++) begin
        hdr_q[i] <= 8'd0;
      end
    end else begin
      sum_q       <= sum_d;
      pend_q      <= pend_d;
      rcv_q       <= rcv_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < HdrBytes; i++) begin
        hdr_q[i] <= hdr_d[i];
      end
    end
  end

  // result payload, loaded only with a last beat
  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) begin
      source_port_o       <= {hdr_d[0], hdr_d[1]};
      dest_port_o         <= {hdr_d[2], hdr_d[3]};
      seq_number_o        <= {hdr_d[4], hdr_d[5], hdr_d[6], hdr_d[7]};
      ack_number_o        <= {hdr_d[8], hdr_d[9], hdr_d[10], hdr_d[11]};
      header_bytes_o      <= hb;
      syn_flag_o          <= |(hdr_d[13] & FlagSyn);
      rst_flag_o          <= |(hdr_d[13] & FlagRst);
      fin_flag_o          <= |(hdr_d[13] & FlagFin);
      ack_flag_o          <= |(hdr_d[13] & FlagAck);
      window_size_o       <= {hdr_d[14], hdr_d[15]};
      checksum_ok_o       <= (csum == rcv_d);
      computed_checksum_o <= csum;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/tcp_header_checksum_verifier_core.sv
// top level of the tcp header checksum verifier
// usage:
//   the input channel carries one segment byte per beat, in network order, with
//   is_last_i marking the final byte; the ip addresses and lengths are sampled
//   only on the first beat of a segment and ignored afterwards
//   the output channel carries one result beat per segment: ports, sequence and
//   ack numbers, header length, flags, window, computed checksum and match bit
//   the checksum covers the ipv4 pseudo-header and the segment, with the
//   checksum field read as zero and an odd final byte padded with zero
// throughput and result path:
//   one byte per cycle sustained while in_stall_o is low; the last byte is
//   written into the queue, then popped and loaded into the output register,
//   raising out_valid_o; the back end's 16 bit end-around adder is combinational
// reset:
//   rst_ni clears the queue, position counter, running sum and output valid
// stall:
//   while out_stall_i holds a result, bytes of the next segment keep flowing
//   until its last beat reaches the back end; the two-entry queue then fills
//   and in_stall_o rises
module tcp_header_checksum_verifier_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        is_last_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] ip_total_len_i,
  input  logic [5:0]  ip_hdr_len_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [31:0] seq_number_o,
  output logic [31:0] ack_number_o,
  output logic [5:0]  header_bytes_o,
  output logic        syn_flag_o,
  output logic        rst_flag_o,
  output logic        fin_flag_o,
  output logic        ack_flag_o,
  output logic [15:0] window_size_o,
  output logic        checksum_ok_o,
  output logic [15:0] computed_checksum_o
);
  import thcv_pkg::*;

  logic  in_acc;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  item_t front_item;
  item_t back_item;

  // stall comes straight from the queue fill level
  assign in_stall_o = q_full;
  assign in_acc     = in_valid_i && !q_full;

  // front: position tracking and classification of each beat
  thcv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (in_acc),
    .data_byte_i    (data_byte_i),
    .is_last_i      (is_last_i),
    .src_ip_i       (src_ip_i),
    .dst_ip_i       (dst_ip_i),
    .ip_total_len_i (ip_total_len_i),
    .ip_hdr_len_i   (ip_hdr_len_i),
    .item_o         (front_item)
  );

  // decoupling queue
  thcv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (back_item)
  );

  // back: checksum, field capture and result register
  thcv_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (q_valid),
    .item_i              (back_item),
    .pop_o               (q_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .source_port_o       (source_port_o),
    .dest_port_o         (dest_port_o),
    .seq_number_o        (seq_number_o),
    .ack_number_o        (ack_number_o),
    .header_bytes_o      (header_bytes_o),
    .syn_flag_o          (syn_flag_o),
    .rst_flag_o          (rst_flag_o),
    .fin_flag_o          (fin_flag_o),
    .ack_flag_o          (ack_flag_o),
    .window_size_o       (window_size_o),
    .checksum_ok_o       (checksum_ok_o),
    .computed_checksum_o (computed_checksum_o)
  );

endmodule

// File: sim/testbench.sv
// self-checking testbench for the tcp header checksum verifier core
`timescale 1ns / 100ps

module testbench;

  // one expected result beat, one member per output port
  typedef struct packed {
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [5:0]  header_bytes;
    logic        syn_flag;
    logic        rst_flag;
    logic        fin_flag;
    logic        ack_flag;
    logic [15:0] window_size;
    logic        checksum_ok;
    logic [15:0] computed_checksum;
  } seg_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        is_last_i;
  logic [31:0] src_ip_i;
  logic [31:0] dst_ip_i;
  logic [15:0] ip_total_len_i;
  logic [5:0]  ip_hdr_len_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] source_port_o;
  logic [15:0] dest_port_o;
  logic [31:0] seq_number_o;
  logic [31:0] ack_number_o;
  logic [5:0]  header_bytes_o;
  logic        syn_flag_o;
  logic        rst_flag_o;
  logic        fin_flag_o;
  logic        ack_flag_o;
  logic [15:0] window_size_o;
  logic        checksum_ok_o;
  logic [15:0] computed_checksum_o;

  tcp_header_checksum_verifier_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .is_last_i          (is_last_i),
    .src_ip_i           (src_ip_i),
    .dst_ip_i           (dst_ip_i),
    .ip_total_len_i     (ip_total_len_i),
    .ip_hdr_len_i       (ip_hdr_len_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .source_port_o      (source_port_o),
    .dest_port_o        (dest_port_o),
    .seq_number_o       (seq_number_o),
    .ack_number_o       (ack_number_o),
    .header_bytes_o     (header_bytes_o),
    .syn_flag_o         (syn_flag_o),
    .rst_flag_o         (rst_flag_o),
    .fin_flag_o         (fin_flag_o),
    .ack_flag_o         (ack_flag_o),
    .window_size_o      (window_size_o),
    .checksum_ok_o      (checksum_ok_o),
    .computed_checksum_o(computed_checksum_o)
  );

  // predictor state, a private copy of what the core tracks per segment
  logic [15:0] seg_sum;
  logic [15:0] seg_pos;
  logic [7:0]  seg_hi_byte;
  logic [7:0]  seg_hdr [0:23];
  logic [15:0] seg_rx_csum;
  logic        seg_open;

  seg_result_t expected_results [$];
  seg_result_t want_r;
  logic [7:0]  seg_buf [$];

  int unsigned mismatches;
  bit          quiet;      // no idling on either side while set

  // one's-complement add with end-around carry
  function automatic logic [15:0] csum_add(logic [15:0] sum, logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, sum} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // pseudo-header words: addresses, protocol, tcp length mod 2^16
  function automatic logic [15:0] pseudo_sum(logic [31:0] sip, logic [31:0] dip,
                                             logic [15:0] tot, logic [5:0] hl);
    logic [15:0] s;
    s = 16'd0;
    s = csum_add(s, sip[31:16]);
    s = csum_add(s, sip[15:0]);
    s = csum_add(s, dip[31:16]);
    s = csum_add(s, dip[15:0]);
    s = csum_add(s, thcv_pkg::ProtoTcp);
    s = csum_add(s, tot - {10'd0, hl});
    return s;
  endfunction

  // advance the predictor by one accepted byte, queue a result on the last one
  function automatic void predict_byte(logic [7:0] b, logic last, logic [31:0] sip,
                                       logic [31:0] dip, logic [15:0] tot,
                                       logic [5:0] hl);
    logic [7:0]  eff;
    logic [5:0]  hb;
    logic [15:0] csum;
    seg_result_t r;
    if (!seg_open) begin
      seg_pos     = 16'd0;
      seg_hi_byte = 8'd0;
      seg_rx_csum = 16'd0;
      for (int i = 0; i < 24; i++) seg_hdr[i] = 8'd0;
      seg_sum  = pseudo_sum(sip, dip, tot, hl);
      seg_open = 1'b1;
    end
    // positions wrap on over-long segments, so capture ors into what is there
    if (seg_pos < 16'd24) seg_hdr[seg_pos] = seg_hdr[seg_pos] | b;
    if (seg_pos == thcv_pkg::CsumHiPos) seg_rx_csum[15:8] = b;
    if (seg_pos == thcv_pkg::CsumLoPos) seg_rx_csum[7:0] = b;
    // checksum field counts as zero in the sum
    eff = (seg_pos == thcv_pkg::CsumHiPos || seg_pos == thcv_pkg::CsumLoPos) ? 8'd0 : b;
    if (!seg_pos[0]) begin
      seg_hi_byte = eff;
      if (last) seg_sum = csum_add(seg_sum, {eff, 8'h00});
    end else begin
      seg_sum = csum_add(seg_sum, {seg_hi_byte, eff});
    end
    seg_pos = seg_pos + 16'd1;
    if (last) begin
      csum = ~seg_sum;
      hb   = {seg_hdr[12][7:4], 2'b00};
      if (hb < thcv_pkg::MinHdrBytes) hb = thcv_pkg::MinHdrBytes;
      r.source_port       = {seg_hdr[0], seg_hdr[1]};
      r.dest_port         = {seg_hdr[2], seg_hdr[3]};
      r.seq_number        = {seg_hdr[4], seg_hdr[5], seg_hdr[6], seg_hdr[7]};
      r.ack_number        = {seg_hdr[8], seg_hdr[9], seg_hdr[10], seg_hdr[11]};
      r.header_bytes      = hb;
      r.syn_flag          = |(seg_hdr[13] & thcv_pkg::FlagSyn);
      r.rst_flag          = |(seg_hdr[13] & thcv_pkg::FlagRst);
      r.fin_flag          = |(seg_hdr[13] & thcv_pkg::FlagFin);
      r.ack_flag          = |(seg_hdr[13] & thcv_pkg::FlagAck);
      r.window_size       = {seg_hdr[14], seg_hdr[15]};
      r.checksum_ok       = (csum == seg_rx_csum);
      r.computed_checksum = csum;
      expected_results.push_back(r);
      seg_open    = 1'b0;
      seg_pos     = 16'd0;
      seg_hi_byte = 8'd0;
      seg_sum     = 16'd0;
    end
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver stall, random except during quiet stretches
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 29);
    end
  end

  // result checker: every accepted beat against the oldest expectation
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result beat with none expected", $realtime);
      end else begin
        want_r = expected_results.pop_front();
        check_field("source_port", want_r.source_port, source_port_o);
        check_field("dest_port", want_r.dest_port, dest_port_o);
        check_field("seq_number", want_r.seq_number, seq_number_o);
        check_field("ack_number", want_r.ack_number, ack_number_o);
        check_field("header_bytes", want_r.header_bytes, header_bytes_o);
        check_field("syn_flag", want_r.syn_flag, syn_flag_o);
        check_field("rst_flag", want_r.rst_flag, rst_flag_o);
        check_field("fin_flag", want_r.fin_flag, fin_flag_o);
        check_field("ack_flag", want_r.ack_flag, ack_flag_o);
        check_field("window_size", want_r.window_size, window_size_o);
        check_field("checksum_ok", want_r.checksum_ok, checksum_ok_o);
        check_field("computed_checksum", want_r.computed_checksum, computed_checksum_o);
      end
    end
  end

  // drive one byte beat, with random idle cycles first, and wait for acceptance
  task automatic send_byte(logic [7:0] b, logic last, logic [31:0] sip, logic [31:0] dip,
                           logic [15:0] tot, logic [5:0] hl);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    is_last_i      <= last;
    src_ip_i       <= sip;
    dst_ip_i       <= dip;
    ip_total_len_i <= tot;
    ip_hdr_len_i   <= hl;
    do @(posedge clk_i); while (in_stall_o);
    predict_byte(b, last, sip, dip, tot, hl);
  endtask

  // stream seg_buf; ip inputs after the first beat are junk the core must ignore
  task automatic send_segment(logic [31:0] sip, logic [31:0] dip, logic [15:0] tot,
                              logic [5:0] hl);
    for (int i = 0; i < seg_buf.size(); i++) begin
      if (i == 0)
        send_byte(seg_buf[i], seg_buf.size() == 1, sip, dip, tot, hl);
      else
        send_byte(seg_buf[i], i == seg_buf.size() - 1, $urandom, $urandom,
                  16'($urandom_range(0, 65535)), 6'($urandom_range(0, 60)));
    end
  endtask

  // write the correct checksum into bytes 16 and 17 of seg_buf, if it reaches them
  task automatic seal_checksum(logic [31:0] sip, logic [31:0] dip, logic [15:0] tot,
                               logic [5:0] hl);
    logic [15:0] s;
    logic [7:0]  hi;
    logic [7:0]  lo;
    s = pseudo_sum(sip, dip, tot, hl);
    for (int i = 0; i < seg_buf.size(); i += 2) begin
      hi = (i == 16) ? 8'd0 : seg_buf[i];
      lo = (i + 1 >= seg_buf.size() || i + 1 == 17) ? 8'd0 : seg_buf[i + 1];
      s  = csum_add(s, {hi, lo});
    end
    if (seg_buf.size() >= 18) begin
      seg_buf[16] = ~s[15:8];
      seg_buf[17] = ~s[7:0];
    end
  endtask

  task automatic fill_random(int n);
    seg_buf.delete();
    repeat (n) seg_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // lower valid and let every expected result come out
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // segments shorter than the header: missing bytes read as zero, odd tail padded
  task automatic test_short_segments();
    seg_buf.delete();
    seg_buf.push_back(8'hA5);
    send_segment(32'h0, 32'h0, 16'd0, 6'd0);
    fill_random(3);
    send_segment(32'h0A000001, 32'hC0A80001, 16'd23, 6'd20);
    fill_random(13);
    send_segment($urandom, $urandom, 16'd33, 6'd20);
  endtask

  // full headers at the extremes of every field, checksum right and wrong
  task automatic test_header_extremes();
    seg_buf.delete();
    repeat (20) seg_buf.push_back(8'hFF);
    seal_checksum(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 6'd60);
    send_segment(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 6'd60);
    seg_buf.delete();
    repeat (20) seg_buf.push_back(8'h00);
    send_segment(32'h0, 32'h0, 16'd0, 6'd0);
  endtask

  // folded sum of all ones gives a computed checksum of zero
  task automatic test_zero_sum();
    seg_buf.delete();
    seg_buf.push_back(8'hFF);
    seg_buf.push_back(8'hF9);
    send_segment(32'h0, 32'h0, 16'd20, 6'd20);
  endtask

  // ip header length above total length: tcp length wraps
  task automatic test_length_mismatch();
    fill_random(24);
    seal_checksum(32'h01020304, 32'h05060708, 16'd10, 6'd60);
    send_segment(32'h01020304, 32'h05060708, 16'd10, 6'd60);
  endtask

  // mostly well-formed segments with random content, some short or inconsistent
  task automatic test_random_segments();
    int          beats;
    int          nseg;
    int          kind;
    int          len;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] tot;
    logic [5:0]  hl;
    beats = 0;
    nseg  = 0;
    while (beats < 1600) begin
      kind = $urandom_range(0, 99);
      if (kind < 10)      len = $urandom_range(1, 19);
      else if (kind < 85) len = $urandom_range(20, 48);
      else                len = $urandom_range(49, 80);
      hl = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 60)) : 6'd20;
      case ($urandom_range(0, 7))
        0:       sip = 32'h0;
        1:       sip = 32'hFFFFFFFF;
        default: sip = $urandom;
      endcase
      dip = ($urandom_range(0, 7) == 0) ? 32'hFFFFFFFF : $urandom;
      tot = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) : 16'(len) + hl;
      fill_random(len);
      if ($urandom_range(0, 1)) seal_checksum(sip, dip, tot, hl);
      quiet = (nseg >= 20 && nseg < 35);
      send_segment(sip, dip, tot, hl);
      beats += len;
      nseg++;
      // now and then let the core run completely dry
      if (nseg % 15 == 0) drain_results();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    data_byte_i    = 8'd0;
    is_last_i      = 1'b0;
    src_ip_i       = 32'd0;
    dst_ip_i       = 32'd0;
    ip_total_len_i = 16'd0;
    ip_hdr_len_i   = 6'd0;
    seg_open       = 1'b0;
    seg_sum        = 16'd0;
    seg_pos        = 16'd0;
    seg_hi_byte    = 8'd0;
    seg_rx_csum    = 16'd0;
    mismatches     = 0;
    quiet          = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_short_segments();
    test_header_extremes();
    test_zero_sum();
    test_length_mismatch();
    test_random_segments();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("testbench NOT OK");
    $finish;
  end

endmodule
